### hdl/csb_pkg.sv
// Shared constants, request and status codes, and controller/datapath
// command and status types for the counting semaphore bank.
// No dependencies.
package csb_pkg;

  // Table sizes
  localparam int NUM_SEMS  = 32;
  localparam int NUM_PROCS = 16;

  // Derived widths
  localparam int SEM_W   = $clog2(NUM_SEMS);
  localparam int PROC_W  = $clog2(NUM_PROCS);
  localparam int ALLOC_W = $clog2(NUM_SEMS + 1);

  // Field widths
  localparam int REQ_W   = 2;
  localparam int SEMID_W = 5;
  localparam int INIT_W  = 15;
  localparam int PID_W   = 4;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 16;

  // Count saturation limits
  localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [CNT_W-1:0] COUNT_MIN = 16'sh8000;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WAIT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SIGNAL = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_ID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted request
    logic rd_sem;   // read count, head and tail of the addressed semaphore
    logic rd_link;  // read the link of the queue head
    logic exec;     // update state and load the result register
    logic link_wr;  // append the caller after the old tail
  } csb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_link;  // valid during exec: a tail link must be written
  } csb_sts_t;

endpackage

### hdl/counting_semaphore_bank.sv
// Top level of the counting semaphore bank: stream ports, sequencer and
// datapath. Depends on csb_pkg, csb_ctrl and csb_datapath.
//
// Usage:
//   The input channel carries one request per transaction: the request kind
//   in in_tuser, the semaphore id, initial count and caller in in_tdata.
//   Every request gives exactly one result transaction on the output
//   channel: the status code in out_tuser, the allocated id, blocked flag
//   and woken process in out_tdata.
//   A request is taken when in_tvalid and in_tready are high; in_tready is
//   high only while the sequencer is idle. Each request then passes a
//   semaphore read, a queue-head link read and an execute step that loads
//   the result register. A wait that blocks on a non-empty queue adds a
//   step to write the tail link. No new request is taken until the
//   current one has passed all its steps.
//   The result register holds a finished result while out_tready is low, and
//   the next request is accepted meanwhile; its execute step waits until
//   the register is free.
//   Synchronous reset clears the allocated count, so no semaphore exists
//   afterwards; the memories are not cleared and need no clearing pass.
module counting_semaphore_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sem_id[4:0], init_value[19:5], proc_id[23:20]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // new_sem[4:0], caller_blocked[5],
                                  // woken_valid[6], woken_proc[10:7], zero[15:11]
  output logic [1:0]  out_tuser   // status[1:0]
);

  csb_pkg::csb_cmd_t cmd;
  csb_pkg::csb_sts_t sts;

  logic [csb_pkg::SEMID_W-1:0] new_sem;
  logic                        caller_blocked;
  logic                        woken_valid;
  logic [csb_pkg::PID_W-1:0]   woken_proc;

  csb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  csb_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (in_tuser),
    .sem_id         (in_tdata[4:0]),
    .init_value     (in_tdata[19:5]),
    .proc_id        (in_tdata[23:20]),
    .status         (out_tuser),
    .new_sem        (new_sem),
    .caller_blocked (caller_blocked),
    .woken_valid    (woken_valid),
    .woken_proc     (woken_proc)
  );

  // Pack result fields, lowest first
  assign out_tdata = {5'd0, woken_proc, woken_valid, caller_blocked, new_sem};

endmodule

### hdl/csb_ctrl.sv
// Sequencer for the counting semaphore bank: walks each request through
// read, execute and link-write steps and owns the result valid flag.
// Depends on csb_pkg.
module csb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output csb_pkg::csb_cmd_t cmd,
  input  csb_pkg::csb_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_SEM,
    S_RD_LINK,
    S_EXEC,
    S_LINK
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Decode commands from the current step
  always_comb begin
    cmd         = '0;
    cmd.load    = (state_r == S_IDLE) && in_tvalid;
    cmd.rd_sem  = (state_r == S_RD_SEM);
    cmd.rd_link = (state_r == S_RD_LINK);
    cmd.exec    = (state_r == S_EXEC) && out_free;
    cmd.link_wr = (state_r == S_LINK);
  end

  // Advance the sequence and track the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_RD_SEM;
        end
        S_RD_SEM:  state_r <= S_RD_LINK;
        S_RD_LINK: state_r <= S_EXEC;
        S_EXEC: begin
          if (out_free) state_r <= sts.need_link ? S_LINK : S_IDLE;
        end
        S_LINK:    state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/csb_datapath.sv
// Datapath of the counting semaphore bank: request registers, count and
// queue memories, saturating update logic and the result register.
// Depends on csb_pkg.
module csb_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csb_pkg::csb_cmd_t           cmd,
  output csb_pkg::csb_sts_t           sts,
  input  logic [csb_pkg::REQ_W-1:0]   req_type,
  input  logic [csb_pkg::SEMID_W-1:0] sem_id,
  input  logic [csb_pkg::INIT_W-1:0]  init_value,
  input  logic [csb_pkg::PID_W-1:0]   proc_id,
  output logic [csb_pkg::STAT_W-1:0]  status,
  output logic [csb_pkg::SEMID_W-1:0] new_sem,
  output logic                        caller_blocked,
  output logic                        woken_valid,
  output logic [csb_pkg::PID_W-1:0]   woken_proc
);

  localparam int SEM_W   = csb_pkg::SEM_W;
  localparam int PROC_W  = csb_pkg::PROC_W;
  localparam int ALLOC_W = csb_pkg::ALLOC_W;
  localparam int CNT_W   = csb_pkg::CNT_W;

  // Semaphore and queue storage
  logic signed [CNT_W-1:0] cnt_mem  [csb_pkg::NUM_SEMS];
  logic [PROC_W-1:0]       head_mem [csb_pkg::NUM_SEMS];
  logic [PROC_W-1:0]       tail_mem [csb_pkg::NUM_SEMS];
  logic [PROC_W-1:0]       link_mem [csb_pkg::NUM_PROCS];

  // Captured request
  logic [csb_pkg::REQ_W-1:0]   req_r;
  logic [csb_pkg::SEMID_W-1:0] sid_r;
  logic [csb_pkg::INIT_W-1:0]  ival_r;
  logic [PROC_W-1:0]           proc_r;

  // Registered memory read data
  logic signed [CNT_W-1:0] rd_cnt_r;
  logic [PROC_W-1:0]       rd_head_r;
  logic [PROC_W-1:0]       rd_tail_r;
  logic [PROC_W-1:0]       rd_link_r;

  logic [ALLOC_W-1:0] alloc_r;

  // Result register
  logic [csb_pkg::STAT_W-1:0]  status_r;
  logic [csb_pkg::SEMID_W-1:0] new_sem_r;
  logic                        blocked_r;
  logic                        wvalid_r;
  logic [csb_pkg::PID_W-1:0]   wproc_r;

  logic [SEM_W-1:0] sem_idx;
  logic [SEM_W-1:0] new_idx;
  logic             table_full;
  logic             bad_id;
  logic signed [CNT_W-1:0] p_after;
  logic signed [CNT_W-1:0] v_after;

  // Update decisions for the exec step
  logic                        do_create;
  logic                        do_wait;
  logic                        do_signal;
  logic                        wait_block;
  logic                        signal_wake;
  logic [csb_pkg::STAT_W-1:0]  status_nxt;
  logic [csb_pkg::SEMID_W-1:0] new_sem_nxt;

  assign sem_idx    = sid_r[SEM_W-1:0];
  assign new_idx    = alloc_r[SEM_W-1:0];
  assign table_full = (alloc_r >= ALLOC_W'(csb_pkg::NUM_SEMS));
  assign bad_id     = (ALLOC_W'(sid_r) >= alloc_r);
  assign p_after    = (rd_cnt_r == csb_pkg::COUNT_MIN) ? csb_pkg::COUNT_MIN
                                                        : rd_cnt_r - 16'sd1;
  assign v_after    = (rd_cnt_r == csb_pkg::COUNT_MAX) ? csb_pkg::COUNT_MAX
                                                        : rd_cnt_r + 16'sd1;

  always_comb begin
    do_create   = 1'b0;
    do_wait     = 1'b0;
    do_signal   = 1'b0;
    status_nxt  = csb_pkg::STAT_OK;
    new_sem_nxt = '0;
    unique case (req_r)
      csb_pkg::REQ_CREATE: begin
        if (table_full) begin
          status_nxt = csb_pkg::STAT_FULL;
        end else begin
          do_create   = 1'b1;
          new_sem_nxt = csb_pkg::SEMID_W'(alloc_r);
        end
      end
      csb_pkg::REQ_WAIT: begin
        if (bad_id) status_nxt = csb_pkg::STAT_BAD_ID;
        else        do_wait    = 1'b1;
      end
      csb_pkg::REQ_SIGNAL: begin
        if (bad_id) status_nxt = csb_pkg::STAT_BAD_ID;
        else        do_signal  = 1'b1;
      end
      default: ;
    endcase
  end

  assign wait_block    = do_wait && (p_after < 0);
  assign signal_wake   = do_signal && (v_after <= 0);
  assign sts.need_link = wait_block && (rd_cnt_r < 0);

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_type;
      sid_r  <= sem_id;
      ival_r <= init_value;
      proc_r <= proc_id[PROC_W-1:0];
    end
  end

  // Read the addressed semaphore, then the link of its queue head
  always_ff @(posedge clk) begin
    if (cmd.rd_sem) begin
      rd_cnt_r  <= cnt_mem[sem_idx];
      rd_head_r <= head_mem[sem_idx];
      rd_tail_r <= tail_mem[sem_idx];
    end
    if (cmd.rd_link) begin
      rd_link_r <= link_mem[rd_head_r];
    end
  end

  // Write the count
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_create) cnt_mem[new_idx] <= CNT_W'(ival_r);
      else if (do_wait) cnt_mem[sem_idx] <= p_after;
      else if (do_signal) cnt_mem[sem_idx] <= v_after;
    end
  end

  // Write queue head and tail
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_create) begin
        head_mem[new_idx] <= '0;
        tail_mem[new_idx] <= '0;
      end else if (wait_block) begin
        if (rd_cnt_r >= 0) head_mem[sem_idx] <= proc_r;
        tail_mem[sem_idx] <= proc_r;
      end else if (signal_wake) begin
        head_mem[sem_idx] <= rd_link_r;
      end
    end
  end

  // Terminate the caller's link, then append it after the old tail
  always_ff @(posedge clk) begin
    if (cmd.exec && wait_block) begin
      link_mem[proc_r] <= '0;
    end else if (cmd.link_wr) begin
      link_mem[rd_tail_r] <= proc_r;
    end
  end

  // Count allocated semaphores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
    end else if (cmd.exec && do_create) begin
      alloc_r <= alloc_r + ALLOC_W'(1);
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= status_nxt;
      new_sem_r <= new_sem_nxt;
      blocked_r <= wait_block;
      wvalid_r  <= signal_wake;
      wproc_r   <= signal_wake ? csb_pkg::PID_W'(rd_head_r) : '0;
    end
  end

  assign status         = status_r;
  assign new_sem        = new_sem_r;
  assign caller_blocked = blocked_r;
  assign woken_valid    = wvalid_r;
  assign woken_proc     = wproc_r;

endmodule
